/* src/mcrb_pkg.sv */
// ----------------------------------------------------------------------------
// mcrb_pkg
// Shared types and constants of the multichannel overwriting ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcrb_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int DEPTH_DEF        = 1024;
    localparam int MAX_READ_DEF     = 64;

    localparam int REQ_W      = 2;
    localparam int CH_FIELD_W = 3;
    localparam int SAMPLE_W   = 32;
    localparam int OFFS_W     = 10;
    localparam int COUNT_W    = 7;
    localparam int ACT_CH_W   = 4;
    localparam int BUF_LEN_W  = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH   = 1'b1;

    localparam logic [ACT_CH_W-1:0]  ACT_CH_RESET  = 4'd8;
    localparam logic [BUF_LEN_W-1:0] BUF_LEN_RESET = 11'd1024;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE       = 2'd0,
        REQ_READ_OLDEST = 2'd1,
        REQ_READ_RECENT = 2'd2,
        REQ_NONE        = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_BAD_CHANNEL = 2'd1,
        STATUS_BAD_COUNT   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_STREAM
    } state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   sample;
        logic [CH_FIELD_W-1:0] channel;
        logic                  last;
        status_t               status;
    } out_word_t;

    // width of tail slot plus start offset, one carry bit on the wider one
    function automatic int mcrb_sum_w(input int depth);
        return (($clog2(depth) > OFFS_W) ? $clog2(depth) : OFFS_W) + 1;
    endfunction

endpackage

`default_nettype wire

/* src/multichannel_overwrite_ring_buffer.sv */
// ----------------------------------------------------------------------------
// multichannel_overwrite_ring_buffer
// Overwriting ring store of 32-bit sample words, one column per channel,
// with per-channel readout from the oldest frame or of the newest samples.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_stall   req_type channel sample_in frame_end
//                                  start_offset read_count
//  out       out_valid / out_stall sample_out channel_out last status
//  cfg       cfg_we                cfg_index cfg_data
//
//  writes are taken while idle and can follow back to back
//  a read of the newest samples is accepted while idle, then in_stall stays
//  high until its read_count words are issued; a read from the oldest frame
//  first holds in_stall while the bit-serial remainder finds the start slot;
//  an error result holds in_stall while its single status word is issued
//  results stream one per cycle from the sample memory read port while
//  out_stall is low
//  after reset all NUM_CHANNELS * 2**ceil(log2(DEPTH)) memory words (8192 by
//  default) are cleared, one word a cycle, with in_stall high
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_overwrite_ring_buffer
    import mcrb_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int DEPTH        = DEPTH_DEF,
    parameter int MAX_READ     = MAX_READ_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [REQ_W-1:0]      req_type,
    input  wire logic [CH_FIELD_W-1:0] channel,
    input  wire logic [SAMPLE_W-1:0]   sample_in,
    input  wire logic                  frame_end,
    input  wire logic [OFFS_W-1:0]     start_offset,
    input  wire logic [COUNT_W-1:0]    read_count,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [SAMPLE_W-1:0]   sample_out,
    output logic      [CH_FIELD_W-1:0] channel_out,
    output logic                       last,
    output logic      [1:0]            status,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W    = $clog2(DEPTH);
    localparam int LEN_W     = $clog2(DEPTH + 1);
    localparam int PW        = LEN_W + 1;
    localparam int SUM_W     = mcrb_sum_w(DEPTH);
    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MEM_AW    = CH_W + SLOT_W;
    localparam int MEM_WORDS = NUM_CHANNELS * (2 ** SLOT_W);

    state_t state_reg, state_next;

    logic [MEM_AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [SLOT_W-1:0]     head_slot_reg, head_slot_next;
    logic [SLOT_W-1:0]     tail_slot_reg, tail_slot_next;
    logic                  full_reg, full_next;
    logic [ACT_CH_W-1:0]   active_ch_reg, active_ch_next;
    logic [BUF_LEN_W-1:0]  buf_len_reg, buf_len_next;

    logic [CH_FIELD_W-1:0] run_ch_reg, run_ch_next;
    logic [SLOT_W-1:0]     run_pos_reg, run_pos_next;
    logic [COUNT_W-1:0]    run_left_reg, run_left_next;
    status_t               run_status_reg, run_status_next;

    logic                  inflight_reg, inflight_next;
    logic [CH_FIELD_W-1:0] infl_ch_reg;
    logic                  infl_last_reg;
    status_t               infl_status_reg;

    logic [31:0]           len32;
    logic [LEN_W-1:0]      eff_len;
    logic                  in_acc;
    logic                  is_write;
    logic                  is_read;
    logic                  ch_ok;
    logic                  cnt_bad;
    logic                  rd_ok;
    logic                  rd_err;
    logic                  head_wrap;
    logic [SLOT_W-1:0]     head_inc;
    logic                  tail_wrap;
    logic [SLOT_W-1:0]     tail_inc;
    logic [PW-1:0]         pr_sum;
    logic [PW-1:0]         pr_mod;
    logic [SLOT_W-1:0]     pos_recent;
    logic [SUM_W-1:0]      sum_oldest;
    logic                  pos_wrap;
    logic [SLOT_W-1:0]     pos_inc;

    logic                  mod_start;
    logic                  mod_done;
    logic [SLOT_W-1:0]     mod_result;

    logic                  ram_we;
    logic [MEM_AW-1:0]     ram_waddr;
    logic [SAMPLE_W-1:0]   ram_wdata;
    logic                  issue;
    logic [MEM_AW-1:0]     ram_raddr;
    logic [SAMPLE_W-1:0]   ram_rdata;

    logic                  q_pop;
    logic [1:0]            q_count;
    logic [2:0]            occ_sum;
    logic [2:0]            occ_lim;
    logic                  can_issue;
    out_word_t             push_word;
    out_word_t             q_word;

    // ------------------------------------------------------------------
    // item decode and slot arithmetic
    // ------------------------------------------------------------------
    always_comb
    begin
        if (buf_len_reg == '0)
        begin
            len32 = 32'd1;
        end
        else if (32'(buf_len_reg) > 32'(DEPTH))
        begin
            len32 = 32'(DEPTH);
        end
        else
        begin
            len32 = 32'(buf_len_reg);
        end
        eff_len = len32[LEN_W-1:0];

        in_acc   = in_valid && !in_stall;
        is_write = (req_type == REQ_WRITE);
        is_read  = (req_type == REQ_READ_OLDEST) || (req_type == REQ_READ_RECENT);
        ch_ok    = (32'(channel) < 32'(active_ch_reg)) && (32'(channel) < 32'(NUM_CHANNELS));
        cnt_bad  = (32'(read_count) > 32'(eff_len)) || (32'(read_count) > 32'(MAX_READ));
        rd_err   = is_read && (!ch_ok || cnt_bad);
        rd_ok    = is_read && ch_ok && !cnt_bad && (read_count != '0);

        head_wrap = (LEN_W'(head_slot_reg) + LEN_W'(1)) == eff_len;
        head_inc  = head_wrap ? '0 : head_slot_reg + SLOT_W'(1);
        tail_wrap = (LEN_W'(tail_slot_reg) + LEN_W'(1)) == eff_len;
        tail_inc  = tail_wrap ? '0 : tail_slot_reg + SLOT_W'(1);
        pos_wrap  = (LEN_W'(run_pos_reg) + LEN_W'(1)) == eff_len;
        pos_inc   = pos_wrap ? '0 : run_pos_reg + SLOT_W'(1);

        // newest samples end just before head; count never exceeds length here
        pr_sum     = PW'(head_slot_reg) + PW'(eff_len) - PW'(read_count);
        pr_mod     = (pr_sum >= PW'(eff_len)) ? pr_sum - PW'(eff_len) : pr_sum;
        pos_recent = pr_mod[SLOT_W-1:0];

        sum_oldest = SUM_W'(tail_slot_reg) + SUM_W'(start_offset);

        q_pop     = out_valid && !out_stall;
        occ_sum   = {1'b0, q_count} + {2'b00, inflight_reg};
        occ_lim   = 3'd2 + {2'b00, q_pop};
        can_issue = occ_sum < occ_lim;
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == MEM_AW'(MEM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc && rd_err)
                begin
                    state_next = ST_STREAM;
                end
                else if (in_acc && rd_ok)
                begin
                    state_next = (req_type == REQ_READ_OLDEST) ? ST_MOD : ST_STREAM;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_STREAM;
                end
            end
            ST_STREAM:
            begin
                if (issue && (run_left_reg == COUNT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        issue     = 1'b0;
        mod_start = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = {CH_W'(channel), head_slot_reg};
        ram_wdata = sample_in;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                ram_we    = in_acc && is_write && ch_ok;
                mod_start = in_acc && rd_ok && (req_type == REQ_READ_OLDEST);
            end
            ST_MOD:
            begin
                in_stall = 1'b1;
            end
            ST_STREAM:
            begin
                issue = can_issue;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // ring pointers, registers and the read run
    // ------------------------------------------------------------------
    always_comb
    begin
        clr_addr_next  = (state_reg == ST_CLEAR) ? clr_addr_reg + MEM_AW'(1) : clr_addr_reg;
        head_slot_next = head_slot_reg;
        tail_slot_next = tail_slot_reg;
        full_next      = full_reg;
        active_ch_next = active_ch_reg;
        buf_len_next   = buf_len_reg;

        if (cfg_we && (cfg_index == CFG_ACTIVE_CHANNELS))
        begin
            active_ch_next = cfg_data[ACT_CH_W-1:0];
        end

        if (cfg_we && (cfg_index == CFG_BUFFER_LENGTH))
        begin
            buf_len_next   = cfg_data[BUF_LEN_W-1:0];
            head_slot_next = '0;
            tail_slot_next = '0;
            full_next      = 1'b0;
        end
        else if (in_acc && is_write && frame_end)
        begin
            // once full, the oldest frame goes with every new one
            head_slot_next = head_inc;
            if (full_reg)
            begin
                tail_slot_next = tail_inc;
            end
            if (head_inc == tail_slot_next)
            begin
                full_next = 1'b1;
            end
        end

        run_ch_next     = run_ch_reg;
        run_pos_next    = run_pos_reg;
        run_left_next   = run_left_reg;
        run_status_next = run_status_reg;
        if ((state_reg == ST_IDLE) && in_acc)
        begin
            run_ch_next   = channel;
            run_pos_next  = pos_recent;
            run_left_next = rd_err ? COUNT_W'(1) : read_count;
            if (!ch_ok)
            begin
                run_status_next = STATUS_BAD_CHANNEL;
            end
            else if (cnt_bad)
            begin
                run_status_next = STATUS_BAD_COUNT;
            end
            else
            begin
                run_status_next = STATUS_OK;
            end
        end
        else if (mod_done)
        begin
            run_pos_next = mod_result;
        end
        else if (issue)
        begin
            run_pos_next  = pos_inc;
            run_left_next = run_left_reg - COUNT_W'(1);
        end

        inflight_next = issue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            head_slot_reg <= '0;
            tail_slot_reg <= '0;
            full_reg      <= 1'b0;
            active_ch_reg <= ACT_CH_RESET;
            buf_len_reg   <= BUF_LEN_RESET;
            inflight_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            head_slot_reg <= head_slot_next;
            tail_slot_reg <= tail_slot_next;
            full_reg      <= full_next;
            active_ch_reg <= active_ch_next;
            buf_len_reg   <= buf_len_next;
            inflight_reg  <= inflight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_ch_reg     <= run_ch_next;
        run_pos_reg    <= run_pos_next;
        run_left_reg   <= run_left_next;
        run_status_reg <= run_status_next;
        if (issue)
        begin
            infl_ch_reg     <= run_ch_reg;
            infl_last_reg   <= (run_left_reg == COUNT_W'(1));
            infl_status_reg <= run_status_reg;
        end
    end

    // ------------------------------------------------------------------
    // units
    // ------------------------------------------------------------------
    assign ram_raddr = {CH_W'(run_ch_reg), run_pos_reg};

    mcrb_sample_ram #(
        .AW    (MEM_AW),
        .WORDS (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mcrb_mod_unit #(
        .DEPTH (DEPTH)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (sum_oldest),
        .divisor  (eff_len),
        .done     (mod_done),
        .result   (mod_result)
    );

    always_comb
    begin
        push_word.sample  = (infl_status_reg == STATUS_OK) ? ram_rdata : '0;
        push_word.channel = infl_ch_reg;
        push_word.last    = infl_last_reg;
        push_word.status  = infl_status_reg;
    end

    mcrb_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (inflight_reg),
        .push_word (push_word),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_word  (q_word),
        .count     (q_count)
    );

    assign sample_out  = q_word.sample;
    assign channel_out = q_word.channel;
    assign last        = q_word.last;
    assign status      = q_word.status;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg |-> (q_count != 2'd2) || q_pop)
        else $error("read word returned into a full result queue");

    a_full_meets: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (head_slot_reg == tail_slot_reg))
        else $error("full store with head and tail apart");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        LEN_W'(head_slot_reg) < eff_len)
        else $error("head slot beyond buffer length");

    a_mod_state: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_MOD))
        else $error("start slot finished outside the offset state");

endmodule

`default_nettype wire

/* src/mcrb_sample_ram.sv */
// ----------------------------------------------------------------------------
// mcrb_sample_ram
// Simple dual-port sample memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrb_sample_ram
    import mcrb_pkg::*;
#(
    parameter int AW    = 13,
    parameter int WORDS = 8192
)
(
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [AW-1:0]       waddr,
    input  wire logic [SAMPLE_W-1:0] wdata,
    input  wire logic                re,
    input  wire logic [AW-1:0]       raddr,
    output logic      [SAMPLE_W-1:0] rdata
);

    logic [SAMPLE_W-1:0] mem [WORDS];
    logic [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/mcrb_mod_unit.sv */
// ----------------------------------------------------------------------------
// mcrb_mod_unit
// Bit-serial remainder unit: dividend mod divisor, one dividend bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrb_mod_unit
    import mcrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [mcrb_sum_w(DEPTH)-1:0]    dividend,
    input  wire logic [$clog2(DEPTH+1)-1:0]      divisor,
    output logic                                 done,
    output logic      [$clog2(DEPTH)-1:0]        result
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = mcrb_sum_w(DEPTH);
    localparam int REM_W  = LEN_W + 1;
    localparam int CNT_W  = $clog2(SUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [SUM_W-1:0] dvd_reg, dvd_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] rem_sub;

    always_comb
    begin
        rem_shift = {rem_reg[REM_W-2:0], dvd_reg[SUM_W-1]};
        rem_sub   = rem_shift - REM_W'(divisor);
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNT_W'(SUM_W);
            dvd_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            dvd_next  = {dvd_reg[SUM_W-2:0], 1'b0};
            rem_next  = (rem_shift >= REM_W'(divisor)) ? rem_sub : rem_shift;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    // remainder stays below the divisor, which never exceeds DEPTH
    assign done   = done_reg;
    assign result = rem_reg[SLOT_W-1:0];

endmodule

`default_nettype wire

/* src/mcrb_out_queue.sv */
// ----------------------------------------------------------------------------
// mcrb_out_queue
// Two-word result queue that decouples memory reads from the output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrb_out_queue
    import mcrb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire out_word_t push_word,
    input  wire logic      out_stall,
    output logic           out_valid,
    output out_word_t      out_word,
    output logic [1:0]     count
);

    out_word_t  slots_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    always_comb
    begin
        pop         = (count_reg != 2'd0) && !out_stall;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign out_valid = (count_reg != 2'd0);
    assign out_word  = slots_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

`default_nettype wire
